/* rtl/lrs_pkg.sv */
package lrs_pkg;

  localparam int FRAC_BITS = 24;
  localparam int CW        = 32;
  localparam int LIMBS     = 4;
  localparam int DW        = 3 * CW + 1;
  localparam int D2W       = 2 * DW;
  localparam int D3W       = 3 * DW;
  localparam int NW        = 4 * CW + 6 * FRAC_BITS;
  localparam int QW        = 4 * CW;
  localparam int SW        = 2 * CW;

  typedef enum logic [1:0] {
    MODE_CONST,
    MODE_INV_SQRT,
    MODE_INV_LIN,
    MODE_INV_34
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE,
    REG_BASE,
    REG_LAMBDA,
    REG_FLOOR
  } reg_idx_t;

  typedef struct packed {
    logic valid;
    logic t_zero;
  } lrs_tag_t;

endpackage

/* rtl/lrs_front.sv */
module lrs_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  lrs_pkg::mode_t                 mode,
  input  logic [lrs_pkg::CW-1:0]         base_rate,
  input  logic [lrs_pkg::CW-1:0]         decay_lambda,
  input  logic                           in_valid,
  input  logic [lrs_pkg::CW-1:0]         iteration,
  output lrs_pkg::lrs_tag_t              tag,
  output logic [lrs_pkg::NW-1:0]         num,
  output logic [lrs_pkg::D3W-1:0]        den
);
  import lrs_pkg::*;

  localparam int SQL   = (D2W + CW - 1) / CW;
  localparam int SQ_ST = LIMBS * LIMBS;
  localparam int CB_ST = SQL * LIMBS;
  localparam int NST   = SQ_ST + CB_ST;

  // stage 1: base products
  logic          v1;
  logic [SW-1:0] bl, bb1;
  logic [CW-1:0] t1;

  // stage 2: split products
  logic          v2;
  logic [SW-1:0] blt_lo, blt_hi, p_ll, p_lh, p_hl, p_hh, bb2;
  logic [CW-1:0] t2;

  // stage 3 onward: square then cube of the denominator, one limb product a stage
  logic           pv   [0:NST];
  logic [DW-1:0]  pd   [0:NST];
  logic [QW-1:0]  pb4  [0:NST];
  logic [SW-1:0]  pbb  [0:NST];
  logic [CW-1:0]  pt   [0:NST];
  logic [D2W-1:0] psq  [0:NST];
  logic [D3W-1:0] pcb  [0:NST];

  logic [D2W-1:0] sq_term [0:SQ_ST-1];
  logic [D3W-1:0] cb_term [0:CB_ST-1];

  for (genvar j = 0; j < LIMBS; j++) begin : g_sq_row
    for (genvar i = 0; i < LIMBS; i++) begin : g_sq_col
      localparam int K = j * LIMBS + i;
      assign sq_term[K] = D2W'(SW'(CW'(pd[K] >> (CW * i))) * SW'(CW'(pd[K] >> (CW * j))))
                          << (CW * (i + j));
    end
  end

  for (genvar j = 0; j < LIMBS; j++) begin : g_cb_row
    for (genvar i = 0; i < SQL; i++) begin : g_cb_col
      localparam int K = j * SQL + i;
      assign cb_term[K] = D3W'(SW'(CW'(psq[SQ_ST + K] >> (CW * i)))
                               * SW'(CW'(pd[SQ_ST + K] >> (CW * j))))
                          << (CW * (i + j));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      for (int k = 0; k <= NST; k++) begin
        pv[k] <= 1'b0;
      end
      tag <= '0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      pv[0] <= v2;
      for (int k = 0; k < NST; k++) begin
        pv[k+1] <= pv[k];
      end
      tag.valid  <= pv[NST];
      tag.t_zero <= (pt[NST] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bl  <= SW'(base_rate) * SW'(decay_lambda);
      bb1 <= SW'(base_rate) * SW'(base_rate);
      t1  <= iteration;

      blt_lo <= SW'(bl[CW-1:0]) * SW'(t1);
      blt_hi <= SW'(bl[SW-1:CW]) * SW'(t1);
      p_ll   <= SW'(bb1[CW-1:0]) * SW'(bb1[CW-1:0]);
      p_lh   <= SW'(bb1[CW-1:0]) * SW'(bb1[SW-1:CW]);
      p_hl   <= SW'(bb1[SW-1:CW]) * SW'(bb1[CW-1:0]);
      p_hh   <= SW'(bb1[SW-1:CW]) * SW'(bb1[SW-1:CW]);
      bb2    <= bb1;
      t2     <= t1;

      pd[0]  <= (DW'(1) << (2 * FRAC_BITS)) + (DW'(blt_hi) << CW) + DW'(blt_lo);
      pb4[0] <= QW'(p_ll) + (QW'(p_lh) << CW) + (QW'(p_hl) << CW) + (QW'(p_hh) << SW);
      pbb[0] <= bb2;
      pt[0]  <= t2;
      psq[0] <= '0;
      pcb[0] <= '0;

      for (int k = 0; k < NST; k++) begin
        pd[k+1]  <= pd[k];
        pb4[k+1] <= pb4[k];
        pbb[k+1] <= pbb[k];
        pt[k+1]  <= pt[k];
      end
      for (int k = 0; k < SQ_ST; k++) begin
        psq[k+1] <= psq[k] + sq_term[k];
        pcb[k+1] <= pcb[k];
      end
      for (int k = SQ_ST; k < NST; k++) begin
        psq[k+1] <= psq[k];
        pcb[k+1] <= pcb[k] + cb_term[k - SQ_ST];
      end

      unique case (mode)
        MODE_INV_SQRT: begin
          num <= NW'(pbb[NST]);
          den <= D3W'(pt[NST]);
        end
        MODE_INV_LIN: begin
          num <= NW'(base_rate) << (2 * FRAC_BITS);
          den <= D3W'(pd[NST]);
        end
        MODE_INV_34: begin
          num <= NW'(pb4[NST]) << (6 * FRAC_BITS);
          den <= pcb[NST];
        end
        default: begin
          num <= '0;
          den <= D3W'(1);
        end
      endcase
    end
  end

endmodule

/* rtl/lrs_div.sv */
module lrs_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  lrs_pkg::lrs_tag_t         tag_in,
  input  logic [lrs_pkg::NW-1:0]    num,
  input  logic [lrs_pkg::D3W-1:0]   den,
  output lrs_pkg::lrs_tag_t         tag_out,
  output logic [lrs_pkg::QW-1:0]    quo
);
  import lrs_pkg::*;

  localparam int XW = D3W + QW;

  lrs_tag_t       tg  [0:QW];
  logic [NW-1:0]  rem [0:QW];
  logic [D3W-1:0] dv  [0:QW];
  logic [QW-1:0]  q   [0:QW];

  assign tg[0]  = tag_in;
  assign rem[0] = num;
  assign dv[0]  = den;
  assign q[0]   = '0;

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int B = QW - 1 - j;
    logic [XW-1:0] dsh;
    logic          fit;

    assign dsh = XW'(dv[j]) << B;
    assign fit = dsh <= XW'(rem[j]);

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[j+1] <= '0;
      end else if (en) begin
        tg[j+1] <= tg[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1]  <= dv[j];
        rem[j+1] <= fit ? rem[j] - dsh[NW-1:0] : rem[j];
        q[j+1]   <= fit ? (q[j] | (QW'(1) << B)) : q[j];
      end
    end
  end

  assign tag_out = tg[QW];
  assign quo     = q[QW];

endmodule

/* rtl/lrs_sqrt_wide.sv */
module lrs_sqrt_wide (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  lrs_pkg::lrs_tag_t         tag_in,
  input  logic [lrs_pkg::QW-1:0]    x,
  output lrs_pkg::lrs_tag_t         tag_out,
  output logic [lrs_pkg::SW-1:0]    root,
  output logic [lrs_pkg::SW-1:0]    pass
);
  import lrs_pkg::*;

  localparam int TW = QW + 2;

  lrs_tag_t      tg  [0:SW];
  logic [QW-1:0] rem [0:SW];
  logic [SW-1:0] rt  [0:SW];
  logic [SW-1:0] ps  [0:SW];

  assign tg[0]  = tag_in;
  assign rem[0] = x;
  assign rt[0]  = '0;
  assign ps[0]  = x[SW-1:0];

  for (genvar j = 0; j < SW; j++) begin : g_step
    localparam int B = SW - 1 - j;
    logic [TW-1:0] trial;
    logic          fit;

    assign trial = (TW'(rt[j]) << (B + 1)) | (TW'(1) << (2 * B));
    assign fit   = trial <= TW'(rem[j]);

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[j+1] <= '0;
      end else if (en) begin
        tg[j+1] <= tg[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ps[j+1]  <= ps[j];
        rem[j+1] <= fit ? rem[j] - trial[QW-1:0] : rem[j];
        rt[j+1]  <= fit ? (rt[j] | (SW'(1) << B)) : rt[j];
      end
    end
  end

  assign tag_out = tg[SW];
  assign root    = rt[SW];
  assign pass    = ps[SW];

endmodule

/* rtl/lrs_sqrt_narrow.sv */
module lrs_sqrt_narrow (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  lrs_pkg::lrs_tag_t         tag_in,
  input  logic [lrs_pkg::SW-1:0]    x,
  input  logic [lrs_pkg::CW-1:0]    pass_in,
  output lrs_pkg::lrs_tag_t         tag_out,
  output logic [lrs_pkg::CW-1:0]    root,
  output logic [lrs_pkg::CW-1:0]    pass
);
  import lrs_pkg::*;

  localparam int TW = SW + 2;

  lrs_tag_t      tg  [0:CW];
  logic [SW-1:0] rem [0:CW];
  logic [CW-1:0] rt  [0:CW];
  logic [CW-1:0] ps  [0:CW];

  assign tg[0]  = tag_in;
  assign rem[0] = x;
  assign rt[0]  = '0;
  assign ps[0]  = pass_in;

  for (genvar j = 0; j < CW; j++) begin : g_step
    localparam int B = CW - 1 - j;
    logic [TW-1:0] trial;
    logic          fit;

    assign trial = (TW'(rt[j]) << (B + 1)) | (TW'(1) << (2 * B));
    assign fit   = trial <= TW'(rem[j]);

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[j+1] <= '0;
      end else if (en) begin
        tg[j+1] <= tg[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ps[j+1]  <= ps[j];
        rem[j+1] <= fit ? rem[j] - trial[SW-1:0] : rem[j];
        rt[j+1]  <= fit ? (rt[j] | (CW'(1) << B)) : rt[j];
      end
    end
  end

  assign tag_out = tg[CW];
  assign root    = rt[CW];
  assign pass    = ps[CW];

endmodule

/* rtl/learning_rate_schedule.sv */
// channel   signals                          width  direction
// input     in_valid in_ready iteration      32     into block
// output    out_valid out_ready step_size    32     out of block
// config    cfg_we cfg_index cfg_data        2/32   into block, write only
//
// one item enters per cycle while in_ready is high; 48 multiply stages,
// 128 restoring divide stages, 64 + 32 square-root stages, one output register
// every stage advances together; the pipeline holds only while the output
// register is full and out_ready is low, so in_ready follows that condition
// synchronous reset clears the valid bits and loads the register defaults
module learning_rate_schedule (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [lrs_pkg::CW-1:0]  iteration,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [lrs_pkg::CW-1:0]  step_size,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [lrs_pkg::CW-1:0]  cfg_data
);
  import lrs_pkg::*;

  mode_t         mode;
  logic [CW-1:0] base_rate, decay_lambda, floor_rate;
  logic          en;

  lrs_tag_t       f_tag, d_tag, w_tag, n_tag;
  logic [NW-1:0]  f_num;
  logic [D3W-1:0] f_den;
  logic [QW-1:0]  d_quo;
  logic [SW-1:0]  w_root, w_pass, n_x;
  logic [CW-1:0]  n_root, n_pass;
  logic [CW-1:0]  sched;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_CONST;
      base_rate    <= CW'(1) << FRAC_BITS;
      decay_lambda <= '0;
      floor_rate   <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE:   mode         <= mode_t'(cfg_data[1:0]);
        REG_BASE:   base_rate    <= cfg_data;
        REG_LAMBDA: decay_lambda <= cfg_data;
        REG_FLOOR:  floor_rate   <= cfg_data;
        default:    ;
      endcase
    end
  end

  lrs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .mode         (mode),
    .base_rate    (base_rate),
    .decay_lambda (decay_lambda),
    .in_valid     (in_valid),
    .iteration    (iteration),
    .tag          (f_tag),
    .num          (f_num),
    .den          (f_den)
  );

  lrs_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_in  (f_tag),
    .num     (f_num),
    .den     (f_den),
    .tag_out (d_tag),
    .quo     (d_quo)
  );

  lrs_sqrt_wide u_sqrt_wide (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_in  (d_tag),
    .x       (d_quo),
    .tag_out (w_tag),
    .root    (w_root),
    .pass    (w_pass)
  );

  assign n_x = (mode == MODE_INV_34) ? w_root : w_pass;

  lrs_sqrt_narrow u_sqrt_narrow (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_in  (w_tag),
    .x       (n_x),
    .pass_in (w_pass[CW-1:0]),
    .tag_out (n_tag),
    .root    (n_root),
    .pass    (n_pass)
  );

  always_comb begin
    unique case (mode)
      MODE_CONST:    sched = base_rate;
      MODE_INV_SQRT: sched = n_tag.t_zero ? '1 : n_root;
      MODE_INV_LIN:  sched = n_pass;
      MODE_INV_34:   sched = n_root;
      default:       sched = base_rate;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= n_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step_size <= (sched < floor_rate) ? floor_rate : sched;
    end
  end

  a_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> step_size >= floor_rate)
    else $error("step size below floor");

  a_const: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == MODE_CONST |->
      step_size == ((base_rate < floor_rate) ? floor_rate : base_rate))
    else $error("constant mode mismatch");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

endmodule

/* tb/sv/tb_learning_rate_schedule.sv */
module tb_learning_rate_schedule;
  import lrs_pkg::*;

  localparam int LATENCY = 273;
  localparam int LONG_HOLD = 600;
  localparam int WATCHDOG_LIMIT = 8000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [CW-1:0] iteration;
  logic out_valid;
  logic out_ready;
  logic [CW-1:0] step_size;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CW-1:0] cfg_data;

  learning_rate_schedule dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .iteration(iteration),
    .out_valid(out_valid), .out_ready(out_ready), .step_size(step_size),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow registers
  mode_t sched_mode;
  logic [CW-1:0] eta;
  logic [CW-1:0] lambda;
  logic [CW-1:0] min_rate;

  logic [CW-1:0] pending_iters[$];
  logic [CW-1:0] expected_steps[$];
  int errors;
  int items_sent;
  int steps_checked;
  int phases_run;
  int watchdog;
  bit in_gaps_on;
  bit out_stalls_on;
  bit pressure_phase;
  bit pressure_done;
  int send_gap;
  int recv_gap;
  int hold_left;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int pick_gap(bit on);
    if (!on) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(10, 40);
  endfunction

  // largest code r with r^pw * x <= y (eta in constant mode), floored at min_rate
  function automatic logic [CW-1:0] schedule_step(logic [CW-1:0] t);
    bit [511:0] b, l, tt, d, x, y, lhs, c;
    logic [CW-1:0] r;
    int pw;
    r = '0;
    if (sched_mode == MODE_CONST) begin
      r = eta;
    end else begin
      b = eta;
      l = lambda;
      tt = t;
      if (sched_mode == MODE_INV_SQRT) begin
        x = tt;
        y = b * b;
        pw = 2;
      end else begin
        d = (512'd1 << (2 * FRAC_BITS)) + b * l * tt;
        if (sched_mode == MODE_INV_LIN) begin
          x = d;
          y = b << (2 * FRAC_BITS);
          pw = 1;
        end else begin
          x = d * d * d;
          y = (b * b * b * b) << (6 * FRAC_BITS);
          pw = 4;
        end
      end
      for (int bit_i = 31; bit_i >= 0; bit_i--) begin
        c = r | (32'd1 << bit_i);
        lhs = x;
        for (int k = 0; k < pw; k++) lhs = lhs * c;
        if (lhs <= y) r = c[CW-1:0];
      end
    end
    if (r < min_rate) r = min_rate;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      iteration <= '0;
      send_gap <= 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        expected_steps.push_back(schedule_step(iteration));
        items_sent++;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_iters.size() > 0) begin
        in_valid <= 1'b1;
        iteration <= pending_iters.pop_front();
        send_gap <= pick_gap(in_gaps_on && !pressure_phase);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
      pressure_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_steps.size() == 0) begin
          $error("unexpected item: step_size %h", step_size);
          errors++;
        end else begin
          logic [CW-1:0] want;
          want = expected_steps.pop_front();
          if (step_size !== want) begin
            $error("step_size mismatch: expected %h actual %h", want, step_size);
            errors++;
          end
          steps_checked++;
        end
      end
      if (pressure_phase && !pressure_done && items_sent > 40) begin
        pressure_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap <= pick_gap(out_stalls_on);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      watchdog <= 0;
    end else if (pending_iters.size() > 0 || expected_steps.size() > 0 || in_valid) begin
      watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MODE: sched_mode = mode_t'(val[1:0]);
      REG_BASE: eta = val;
      REG_LAMBDA: lambda = val;
      default: min_rate = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(mode_t m, logic [CW-1:0] b, logic [CW-1:0] l, logic [CW-1:0] f);
    write_reg(REG_MODE, CW'(m));
    write_reg(REG_BASE, b);
    write_reg(REG_LAMBDA, l);
    write_reg(REG_FLOOR, f);
  endtask

  task automatic drain;
    while (pending_iters.size() > 0 || in_valid || expected_steps.size() > 0)
      @(negedge clk);
    repeat (3) @(posedge clk);
    phases_run++;
  endtask

  function automatic logic [CW-1:0] rand_rate();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return 32'd1 << FRAC_BITS;
      3: return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_iter();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 16);
      1: return $urandom_range(0, 100000);
      2: return '1 - $urandom_range(0, 16);
      3: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [CW-1:0] edge_iters[10];
    edge_iters = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd100, 32'h8000_0000,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF};
    errors = 0;
    items_sent = 0;
    steps_checked = 0;
    phases_run = 0;
    watchdog = 0;
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    pressure_phase = 1'b0;
    sched_mode = MODE_CONST;
    eta = 32'd1 << FRAC_BITS;
    lambda = '0;
    min_rate = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    iteration = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset defaults, then each mode with edge iterations
    foreach (edge_iters[i]) pending_iters.push_back(edge_iters[i]);
    drain();
    for (int m = 1; m < 4; m++) begin
      configure(mode_t'(m), 32'd1 << FRAC_BITS, 32'd1 << (FRAC_BITS - 4), '0);
      foreach (edge_iters[i]) pending_iters.push_back(edge_iters[i]);
      drain();
    end
    // zero base, max base and max lambda, floor above everything
    configure(MODE_INV_LIN, '0, '1, 32'd3);
    pending_iters.push_back(32'd7);
    pending_iters.push_back('1);
    drain();
    configure(MODE_INV_34, '1, '1, '0);
    pending_iters.push_back(32'd0);
    pending_iters.push_back('1);
    drain();
    configure(MODE_INV_SQRT, '1, '0, '1);
    pending_iters.push_back(32'd9);
    drain();

    // long receiver hold with back-to-back input
    pressure_phase = 1'b1;
    configure(MODE_INV_34, rand_rate(), rand_rate(), '0);
    for (int i = 0; i < 400; i++) pending_iters.push_back(rand_iter());
    drain();
    pressure_phase = 1'b0;

    for (int p = 0; p < 16; p++) begin
      in_gaps_on = (p % 4) != 0;
      out_stalls_on = (p % 4) != 1;
      configure(mode_t'($urandom_range(0, 3)), rand_rate(), rand_rate(),
                ($urandom_range(0, 2) == 0) ? rand_rate() : '0);
      for (int i = 0; i < 100; i++) pending_iters.push_back(rand_iter());
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk);
    $display("covered %0d items over %0d config phases, all four modes, long output hold",
             items_sent, phases_run);
    $display("checked %0d step sizes, %0d mismatches", steps_checked, errors);
    if (errors == 0 && expected_steps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* learning_rate_schedule.f */
rtl/lrs_pkg.sv
rtl/lrs_front.sv
rtl/lrs_div.sv
rtl/lrs_sqrt_wide.sv
rtl/lrs_sqrt_narrow.sv
rtl/learning_rate_schedule.sv
tb/sv/tb_learning_rate_schedule.sv
